@@ design/hmbs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Heightmap bilinear sampler package
// Shared constants and the sequencer state type of the bilinear height sampler.
// ----------------------------------------------------------------------------
package hmbs_pkg;

	localparam int GRID_SIZE_DEF = 128;
	localparam int FRAC_BITS_DEF = 8;

	localparam int COL_W    = 7;
	localparam int HEIGHT_W = 16;
	localparam int COORD_W  = 16;
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 16;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_A,
		ST_RD_B,
		ST_RD_C,
		ST_RD_D,
		ST_MUL1,
		ST_ADD1,
		ST_MUL2,
		ST_ADD2,
		ST_MUL3,
		ST_ADD3,
		ST_OUT
	} hmbs_state_t;

endpackage
`default_nettype wire

@@ design/heightmap_bilinear_sample.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Heightmap bilinear sampler
// Holds a square grid of signed Q8.8 heights and returns bilinear samples.
// ----------------------------------------------------------------------------
// Channel   Direction  Carries
// s_axis    in         write request (height) or query request (x, y)
// m_axis    out        one result per query: altitude, out-of-range flag
//
// A write request is done while the block is idle. An in-range query makes
// four reads of the single-port grid memory, then three multiply and
// round-add steps on one shared multiplier and adder, before its result
// shows. An out-of-range query goes straight to its result. The block takes
// no new request until the result is taken. Reset clears only the sequencer.
// ----------------------------------------------------------------------------
module heightmap_bilinear_sample
	import hmbs_pkg::*;
#(
	parameter int GRID_SIZE = GRID_SIZE_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// write_col[6:0], write_row[13:7], height_value[29:14], x_coord[45:30],
	// y_coord[61:46], zero fill[63:62]
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	// op[0]
	input  wire logic                  s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// altitude[15:0]
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,
	// out_of_range[0]
	output logic                       m_axis_tuser
);

	localparam int DEPTH = GRID_SIZE * GRID_SIZE;
	localparam int AW    = $clog2(DEPTH);
	localparam int IW    = $clog2(GRID_SIZE);
	localparam int XW    = COORD_W + 1;
	localparam int DW    = HEIGHT_W + 1;
	localparam int PW    = FRAC_BITS + 1 + DW;
	localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FRAC_BITS - 1);

	hmbs_state_t state_q, state_nx;

	logic [COL_W-1:0]     in_col, in_row;
	logic [HEIGHT_W-1:0]  in_height;
	logic [COORD_W-1:0]   in_x, in_y;
	logic signed [XW-1:0] ix, iy;
	logic                 q_oor;
	logic                 in_acc;
	logic                 wr_ok;

	logic [IW-1:0]        i_q, j_q;
	logic [FRAC_BITS-1:0] fx_q, fy_q;
	logic [HEIGHT_W-1:0]  a_q, b_q, c_q, d_q, z1_q, z2_q, alt_q;
	logic                 oor_q;
	logic signed [PW-1:0] prod_q;

	logic [HEIGHT_W-1:0]  mem [DEPTH];
	logic [HEIGHT_W-1:0]  rd_q;
	logic [AW-1:0]        mem_addr;
	logic                 mem_we;
	logic [IW-1:0]        rd_col, rd_row;

	logic [FRAC_BITS-1:0] mul_frac;
	logic [HEIGHT_W-1:0]  mul_hi, mul_lo, add_base;
	logic signed [DW-1:0] diff;
	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] rnd, lerp_sum;
	logic [HEIGHT_W-1:0]  lerp_res;

	assign in_col    = s_axis_tdata[6:0];
	assign in_row    = s_axis_tdata[13:7];
	assign in_height = s_axis_tdata[29:14];
	assign in_x      = s_axis_tdata[45:30];
	assign in_y      = s_axis_tdata[61:46];

	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign ix = $signed({in_x[COORD_W-1], in_x}) >>> FRAC_BITS;
	assign iy = $signed({in_y[COORD_W-1], in_y}) >>> FRAC_BITS;
	assign q_oor = ix[XW-1] || iy[XW-1] ||
		($unsigned(ix) >= XW'(GRID_SIZE - 1)) || ($unsigned(iy) >= XW'(GRID_SIZE - 1));
	assign wr_ok = (32'(in_col) < 32'(GRID_SIZE)) && (32'(in_row) < 32'(GRID_SIZE));

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && (s_axis_tuser == OP_QUERY)) begin
					state_nx = q_oor ? ST_OUT : ST_RD_A;
				end
			end
			ST_RD_A: state_nx = ST_RD_B;
			ST_RD_B: state_nx = ST_RD_C;
			ST_RD_C: state_nx = ST_RD_D;
			ST_RD_D: state_nx = ST_MUL1;
			ST_MUL1: state_nx = ST_ADD1;
			ST_ADD1: state_nx = ST_MUL2;
			ST_MUL2: state_nx = ST_ADD2;
			ST_ADD2: state_nx = ST_MUL3;
			ST_MUL3: state_nx = ST_ADD3;
			ST_ADD3: state_nx = ST_OUT;
			ST_OUT: begin
				if (m_axis_tready) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		m_axis_tvalid = 1'b0;
		mem_we   = 1'b0;
		rd_col   = i_q;
		rd_row   = j_q;
		mul_frac = '0;
		mul_hi   = '0;
		mul_lo   = '0;
		add_base = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				mem_we = in_acc && (s_axis_tuser == OP_WRITE) && wr_ok;
			end
			ST_RD_B: rd_col = i_q + IW'(1);
			ST_RD_C: rd_row = j_q + IW'(1);
			ST_RD_D: begin
				rd_col = i_q + IW'(1);
				rd_row = j_q + IW'(1);
			end
			ST_MUL1: begin
				mul_frac = fx_q;
				mul_hi   = b_q;
				mul_lo   = a_q;
			end
			ST_ADD1: add_base = a_q;
			ST_MUL2: begin
				mul_frac = fx_q;
				mul_hi   = d_q;
				mul_lo   = c_q;
			end
			ST_ADD2: add_base = c_q;
			ST_MUL3: begin
				mul_frac = fy_q;
				mul_hi   = z2_q;
				mul_lo   = z1_q;
			end
			ST_ADD3: add_base = z1_q;
			ST_OUT: m_axis_tvalid = 1'b1;
			default: begin
			end
		endcase
	end

	always_comb begin
		if (state_q == ST_IDLE) begin
			mem_addr = AW'(32'(in_row) * 32'(GRID_SIZE) + 32'(in_col));
		end else begin
			mem_addr = AW'(32'(rd_row) * 32'(GRID_SIZE) + 32'(rd_col));
		end
	end

	assign diff = $signed({mul_hi[HEIGHT_W-1], mul_hi}) - $signed({mul_lo[HEIGHT_W-1], mul_lo});
	assign prod = PW'($signed({1'b0, mul_frac})) * PW'(diff);
	assign rnd = (prod_q + HALF) >>> FRAC_BITS;
	assign lerp_sum = rnd + PW'($signed(add_base));
	assign lerp_res = lerp_sum[HEIGHT_W-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= in_height;
		end
		rd_q <= mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc && s_axis_tuser == OP_QUERY) begin
			i_q   <= ix[IW-1:0];
			j_q   <= iy[IW-1:0];
			fx_q  <= in_x[FRAC_BITS-1:0];
			fy_q  <= in_y[FRAC_BITS-1:0];
			oor_q <= q_oor;
			alt_q <= '0;
		end
		if (state_q == ST_RD_B) a_q <= rd_q;
		if (state_q == ST_RD_C) b_q <= rd_q;
		if (state_q == ST_RD_D) c_q <= rd_q;
		if (state_q == ST_MUL1) d_q <= rd_q;
		if (state_q == ST_MUL1 || state_q == ST_MUL2 || state_q == ST_MUL3) begin
			prod_q <= prod;
		end
		if (state_q == ST_ADD1) z1_q <= lerp_res;
		if (state_q == ST_ADD2) z2_q <= lerp_res;
		if (state_q == ST_ADD3) alt_q <= lerp_res;
	end

	assign m_axis_tdata = alt_q;
	assign m_axis_tuser = oor_q;

endmodule
`default_nettype wire
